/* sv/pip_pkg.sv */
`timescale 1ns / 1ps

package pip_pkg;

  // Item kinds carried in the input tuser bit.
  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  // Result codes for the location field.
  localparam int unsigned LOC_W = 2;
  localparam logic [LOC_W-1:0] LOC_OUTSIDE  = 2'd0;
  localparam logic [LOC_W-1:0] LOC_BOUNDARY = 2'd1;
  localparam logic [LOC_W-1:0] LOC_INSIDE   = 2'd2;

  // Output tdata is the location code padded to a whole byte.
  localparam int unsigned OUT_TDATA_W = 8;

  // Control that travels alongside the operands of one item.
  typedef struct packed {
    logic is_vertex;  // item is a polygon vertex
    logic last;       // vertex closes the polygon
    logic e1_valid;   // edge from the previous vertex to this one is taken
    logic e2_valid;   // closing edge from this vertex to the first one is taken
  } stage_ctl_t;

  // Outcome of one edge test.
  typedef struct packed {
    logic bnd;  // point lies on the edge
    logic tog;  // edge crosses the ray and flips the parity
  } edge_flags_t;

endpackage

/* sv/pip_front.sv */
`timescale 1ns / 1ps

module pip_front import pip_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          consume,
  input  logic                          kind,
  input  logic                          last,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  output logic                          valid,
  output stage_ctl_t                    ctl,
  output logic signed [COORD_WIDTH:0]   d_prev_x,
  output logic signed [COORD_WIDTH:0]   d_prev_y,
  output logic signed [COORD_WIDTH:0]   d_cur_x,
  output logic signed [COORD_WIDTH:0]   d_cur_y,
  output logic signed [COORD_WIDTH:0]   d_first_x,
  output logic signed [COORD_WIDTH:0]   d_first_y
);

  localparam int unsigned DW = COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] query_x;
  logic signed [COORD_WIDTH-1:0] query_y;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] prev_x;
  logic signed [COORD_WIDTH-1:0] prev_y;
  logic                          have_first;
  logic signed [COORD_WIDTH-1:0] close_x;
  logic signed [COORD_WIDTH-1:0] close_y;
  logic                          is_vertex;

  assign is_vertex = (kind == KIND_VERTEX);

  // A single-vertex polygon closes onto itself.
  assign close_x = have_first ? first_x : x;
  assign close_y = have_first ? first_y : y;

  // Polygon tracking state, advanced on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      query_x    <= '0;
      query_y    <= '0;
      first_x    <= '0;
      first_y    <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      have_first <= 1'b0;
    end else if (accept) begin
      if (!is_vertex) begin
        query_x    <= x;
        query_y    <= y;
        have_first <= 1'b0;
      end else begin
        if (!have_first) begin
          first_x <= x;
          first_y <= y;
        end
        prev_x     <= x;
        prev_y     <= y;
        have_first <= !last;
      end
    end
  end

  // Stage one valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (consume) begin
      valid <= 1'b0;
    end
  end

  // Edge vectors relative to the query point, all exact at one extra bit.
  always_ff @(posedge clk) begin
    if (accept) begin
      ctl.is_vertex <= is_vertex;
      ctl.last      <= last;
      ctl.e1_valid  <= is_vertex && have_first;
      ctl.e2_valid  <= is_vertex && last;
      d_prev_x      <= DW'({prev_x[COORD_WIDTH-1], prev_x} - {query_x[COORD_WIDTH-1], query_x});
      d_prev_y      <= DW'({prev_y[COORD_WIDTH-1], prev_y} - {query_y[COORD_WIDTH-1], query_y});
      d_cur_x       <= DW'({x[COORD_WIDTH-1], x} - {query_x[COORD_WIDTH-1], query_x});
      d_cur_y       <= DW'({y[COORD_WIDTH-1], y} - {query_y[COORD_WIDTH-1], query_y});
      d_first_x     <= DW'({close_x[COORD_WIDTH-1], close_x}
                           - {query_x[COORD_WIDTH-1], query_x});
      d_first_y     <= DW'({close_y[COORD_WIDTH-1], close_y}
                           - {query_y[COORD_WIDTH-1], query_y});
    end
  end

endmodule

/* sv/pip_edge_prod.sv */
`timescale 1ns / 1ps

module pip_edge_prod #(
  parameter int unsigned DW = 17
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic signed [DW-1:0]   ax,
  input  logic signed [DW-1:0]   ay,
  input  logic signed [DW-1:0]   bx,
  input  logic signed [DW-1:0]   by,
  output logic signed [2*DW-1:0] p_axby,
  output logic signed [2*DW-1:0] p_aybx,
  output logic signed [2*DW-1:0] p_axbx,
  output logic signed [2*DW-1:0] p_ayby,
  output logic                   span_up,
  output logic                   span_down
);

  logic signed [2*DW-1:0] m_axby;
  logic signed [2*DW-1:0] m_aybx;
  logic signed [2*DW-1:0] m_axbx;
  logic signed [2*DW-1:0] m_ayby;

  // Four signed products for the cross and dot terms of one edge.
  assign m_axby = ax * by;
  assign m_aybx = ay * bx;
  assign m_axbx = ax * bx;
  assign m_ayby = ay * by;

  // Register the products and whether the edge spans the ray level upward or downward.
  always_ff @(posedge clk) begin
    if (load) begin
      p_axby    <= m_axby;
      p_aybx    <= m_aybx;
      p_axbx    <= m_axbx;
      p_ayby    <= m_ayby;
      span_up   <= (ay <= 0) && (by > 0);
      span_down <= (by <= 0) && (ay > 0);
    end
  end

endmodule

/* sv/point_in_polygon_test.sv */
`timescale 1ns / 1ps

// Point-in-polygon test by crossing number on exact integer coordinates.
// The input stream carries items: tuser = 0 sets the query point (x, y) and
// starts a polygon, tuser = 1 is a vertex, and tlast on a vertex closes the
// polygon. Each later vertex closes the edge from its predecessor; the last one
// also closes the edge back to the first vertex. One result per closed polygon
// appears on the output stream: 0 outside, 1 on the boundary, 2 strictly inside.
// The pipeline has three registers: edge vectors, edge products, and the
// output register. A result enters it when its last vertex leaves the product
// stage. One item is accepted every cycle while input tready is high; the
// per-edge multipliers are fully pipelined and the parity and boundary flags
// fold combinationally. When the receiver stalls, items that produce no result
// keep flowing; input tready falls only once a result item reaches the product
// stage and the output register is still held, and the pipeline is then full.
// Reset clears the query point and polygon state to zero and empties the
// pipeline; a vertex sent before any query is tested against point (0, 0).

module point_in_polygon_test import pip_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // x [COORD_WIDTH-1:0], y [2*COORD_WIDTH-1:COORD_WIDTH], zero pad to bytes
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
  // kind: 0 query point, 1 vertex
  input  logic                                   s_tuser,
  input  logic                                   s_tlast,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // location [1:0], zero pad to a byte
  output logic [OUT_TDATA_W-1:0]                 m_tdata
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  logic                          accept;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;

  logic                          v1;
  stage_ctl_t                    ctl1;
  logic signed [DW-1:0]          d_prev_x;
  logic signed [DW-1:0]          d_prev_y;
  logic signed [DW-1:0]          d_cur_x;
  logic signed [DW-1:0]          d_cur_y;
  logic signed [DW-1:0]          d_first_x;
  logic signed [DW-1:0]          d_first_y;

  logic                          v2;
  stage_ctl_t                    ctl2;
  logic signed [PW-1:0]          e1_axby, e1_aybx, e1_axbx, e1_ayby;
  logic signed [PW-1:0]          e2_axby, e2_aybx, e2_axbx, e2_ayby;
  logic                          e1_up, e1_down, e2_up, e2_down;

  logic                          res2;
  logic                          out_free;
  logic                          fire2;
  logic                          ready2;
  logic                          fire1;

  edge_flags_t                   f1;
  edge_flags_t                   f2;
  logic                          acc_bnd;
  logic                          acc_par;
  logic                          bnd_next;
  logic                          par_next;
  logic [LOC_W-1:0]              loc_next;

  // Classify one edge from its registered products.
  function automatic edge_flags_t edge_eval(
    input logic signed [PW-1:0] axby,
    input logic signed [PW-1:0] aybx,
    input logic signed [PW-1:0] axbx,
    input logic signed [PW-1:0] ayby,
    input logic                 up,
    input logic                 down
  );
    logic signed [PW:0] cr;
    logic signed [PW:0] dt;
    edge_flags_t        f;
    cr    = {axby[PW-1], axby} - {aybx[PW-1], aybx};
    dt    = {axbx[PW-1], axbx} + {ayby[PW-1], ayby};
    f.bnd = (cr == '0) && (dt <= 0);
    f.tog = (up && (cr < 0)) || (down && (cr > 0));
    return f;
  endfunction

  assign in_x   = s_tdata[COORD_WIDTH-1:0];
  assign in_y   = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign accept = s_tvalid && s_tready;

  // Pipeline flow: only an item that carries a result waits on the output register.
  assign res2     = v2 && ctl2.is_vertex && ctl2.last;
  assign out_free = !m_tvalid || m_tready;
  assign fire2    = v2 && (!res2 || out_free);
  assign ready2   = !v2 || fire2;
  assign fire1    = v1 && ready2;
  assign s_tready = !v1 || ready2;

  pip_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .consume   (fire1),
    .kind      (s_tuser),
    .last      (s_tlast),
    .x         (in_x),
    .y         (in_y),
    .valid     (v1),
    .ctl       (ctl1),
    .d_prev_x  (d_prev_x),
    .d_prev_y  (d_prev_y),
    .d_cur_x   (d_cur_x),
    .d_cur_y   (d_cur_y),
    .d_first_x (d_first_x),
    .d_first_y (d_first_y)
  );

  // Edge from the previous vertex to the current one.
  pip_edge_prod #(
    .DW (DW)
  ) u_edge_prev (
    .clk       (clk),
    .load      (fire1),
    .ax        (d_prev_x),
    .ay        (d_prev_y),
    .bx        (d_cur_x),
    .by        (d_cur_y),
    .p_axby    (e1_axby),
    .p_aybx    (e1_aybx),
    .p_axbx    (e1_axbx),
    .p_ayby    (e1_ayby),
    .span_up   (e1_up),
    .span_down (e1_down)
  );

  // Closing edge from the current vertex back to the first one.
  pip_edge_prod #(
    .DW (DW)
  ) u_edge_close (
    .clk       (clk),
    .load      (fire1),
    .ax        (d_cur_x),
    .ay        (d_cur_y),
    .bx        (d_first_x),
    .by        (d_first_y),
    .p_axby    (e2_axby),
    .p_aybx    (e2_aybx),
    .p_axbx    (e2_axbx),
    .p_ayby    (e2_ayby),
    .span_up   (e2_up),
    .span_down (e2_down)
  );

  // Stage two control.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= fire1 || (v2 && !fire2);
    end
  end

  always_ff @(posedge clk) begin
    if (fire1) begin
      ctl2 <= ctl1;
    end
  end

  // Fold both edges into the sticky boundary mark and the crossing parity.
  // Once the boundary mark is set, the parity no longer matters.
  assign f1       = edge_eval(e1_axby, e1_aybx, e1_axbx, e1_ayby, e1_up, e1_down);
  assign f2       = edge_eval(e2_axby, e2_aybx, e2_axbx, e2_ayby, e2_up, e2_down);
  assign bnd_next = acc_bnd || (ctl2.e1_valid && f1.bnd) || (ctl2.e2_valid && f2.bnd);
  assign par_next = acc_par ^ (ctl2.e1_valid && f1.tog) ^ (ctl2.e2_valid && f2.tog);
  assign loc_next = bnd_next ? LOC_BOUNDARY : (par_next ? LOC_INSIDE : LOC_OUTSIDE);

  // Polygon accumulators, cleared by a query item and after each result.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_bnd <= 1'b0;
      acc_par <= 1'b0;
    end else if (fire2) begin
      if (!ctl2.is_vertex || ctl2.last) begin
        acc_bnd <= 1'b0;
        acc_par <= 1'b0;
      end else begin
        acc_bnd <= bnd_next;
        acc_par <= par_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire2 && res2) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire2 && res2) begin
      m_tdata <= {{(OUT_TDATA_W-LOC_W){1'b0}}, loc_next};
    end
  end

  // A new result only ever comes from a closing vertex leaving the product stage.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(fire2 && res2))
    else $error("output valid rose without a closing vertex");

  // Reported locations are always one of the three defined codes.
  a_location_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[LOC_W-1:0] == LOC_OUTSIDE) ||
                 (m_tdata[LOC_W-1:0] == LOC_BOUNDARY) ||
                 (m_tdata[LOC_W-1:0] == LOC_INSIDE))
    else $error("undefined location code on output");

  // The accumulators start clean after every result.
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (fire2 && res2) |=> (!acc_bnd && !acc_par))
    else $error("polygon accumulators not cleared after a result");

  // Input back-pressure only when both pipeline stages are occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && res2))
    else $error("input stalled while the pipeline had room");

endmodule

/* verif/point_in_polygon_test_checker.sv */
`timescale 1ns / 1ps

// Watches both streams of the point-in-polygon block, predicts the location of
// each closed polygon and compares it with the result transfers in order.
module point_in_polygon_test_checker import pip_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  // x [COORD_WIDTH-1:0], y [2*COORD_WIDTH-1:COORD_WIDTH], zero pad to bytes
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  // kind: 0 query point, 1 vertex
  input  logic                               s_tuser,
  input  logic                               s_tlast,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  // location [1:0], zero pad to a byte
  input  logic [OUT_TDATA_W-1:0]             m_tdata,
  output int                                 fail_count,
  output int                                 pending_count,
  output int                                 n_outside,
  output int                                 n_boundary,
  output int                                 n_inside
);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // Shadow copy of the block's polygon state.
  coord_t query_px, query_py;
  coord_t first_vx, first_vy;
  coord_t prev_vx, prev_vy;
  bit     got_first;
  bit     crossing_odd;
  bit     edge_hit;

  logic [LOC_W-1:0] loc_expected [$];
  logic [LOC_W-1:0] loc_want;
  int               result_index;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    n_outside     = 0;
    n_boundary    = 0;
    n_inside      = 0;
    result_index  = 0;
  end

  // Fold one edge (u to v) into the boundary mark and the crossing parity.
  function automatic void fold_edge(coord_t ux, coord_t uy, coord_t vx, coord_t vy);
    longint ax, ay, bx, by, cr, dt, t;
    ax = longint'(ux) - longint'(query_px);
    ay = longint'(uy) - longint'(query_py);
    bx = longint'(vx) - longint'(query_px);
    by = longint'(vy) - longint'(query_py);
    cr = ax * by - ay * bx;
    dt = ax * bx + ay * by;
    if (edge_hit) return;
    if (cr == 0 && dt <= 0) begin
      edge_hit = 1'b1;
      return;
    end
    // Order the ends by y so the half-open crossing test sees a rising edge.
    if (ay > by) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
      cr = -cr;
    end
    if (ay <= 0 && by > 0 && cr < 0) crossing_odd = ~crossing_odd;
  endfunction

  // Advance the shadow state by one accepted input item.
  function automatic void take_item(logic kind, coord_t x, coord_t y, logic lst);
    if (kind == KIND_QUERY) begin
      query_px     = x;
      query_py     = y;
      got_first    = 1'b0;
      crossing_odd = 1'b0;
      edge_hit     = 1'b0;
      return;
    end
    if (!got_first) begin
      first_vx  = x;
      first_vy  = y;
      got_first = 1'b1;
    end else begin
      fold_edge(prev_vx, prev_vy, x, y);
    end
    prev_vx = x;
    prev_vy = y;
    if (lst) begin
      fold_edge(x, y, first_vx, first_vy);
      loc_expected.push_back(edge_hit ? LOC_BOUNDARY :
                             (crossing_odd ? LOC_INSIDE : LOC_OUTSIDE));
      got_first    = 1'b0;
      crossing_odd = 1'b0;
      edge_hit     = 1'b0;
    end
  endfunction

  // Compare result transfers first, then predict from the input transfer.
  always @(posedge clk) begin
    if (rst) begin
      query_px     = '0;
      query_py     = '0;
      first_vx     = '0;
      first_vy     = '0;
      prev_vx      = '0;
      prev_vy      = '0;
      got_first    = 1'b0;
      crossing_odd = 1'b0;
      edge_hit     = 1'b0;
      loc_expected.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (loc_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Unexpected result transfer %0d: location %0d with none pending",
                     result_index, m_tdata[LOC_W-1:0]);
        end else begin
          loc_want = loc_expected.pop_front();
          case (loc_want)
            LOC_OUTSIDE:  n_outside++;
            LOC_BOUNDARY: n_boundary++;
            default:      n_inside++;
          endcase
          if (m_tdata[LOC_W-1:0] !== loc_want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Result %0d location mismatch: expected %0d, got %0d",
                       result_index, loc_want, m_tdata[LOC_W-1:0]);
          end
        end
        result_index++;
      end
      if (s_tvalid && s_tready)
        take_item(s_tuser, coord_t'(s_tdata[COORD_WIDTH-1:0]),
                  coord_t'(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]), s_tlast);
    end
    pending_count = loc_expected.size();
  end

endmodule

/* verif/point_in_polygon_test_tb.sv */
`timescale 1ns / 1ps

// Drives query points and polygons into the block, stalls the result side at
// random, and reports the verdict from the checker's failure count.
module point_in_polygon_test_tb import pip_pkg::*;;

  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned IN_W        = ((2*COORD_WIDTH+7)/8)*8;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata  = '0;
  logic                   s_tuser  = 1'b0;
  logic                   s_tlast  = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int fail_count, pending_count, n_outside, n_boundary, n_inside;
  int items_sent = 0;
  bit quiet      = 1'b0;

  point_in_polygon_test #(.COORD_WIDTH(COORD_WIDTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  point_in_polygon_test_checker #(.COORD_WIDTH(COORD_WIDTH)) i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .n_outside     (n_outside),
    .n_boundary    (n_boundary),
    .n_inside      (n_inside)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, with a chance of 9 in 100, outside the quiet stretch.
  always @(negedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 9);
  end

  // One item, with random idle cycles in front of it, held until its transfer.
  // Coordinates are taken as integers and cut to the field width here.
  task automatic send_item(logic kind, int x, int y, logic lst);
    while (!quiet && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tlast  <= lst;
    s_tdata  <= {COORD_WIDTH'(y), COORD_WIDTH'(x)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted result has come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  // Coordinates: a tight grid, a medium range, the full range, or the extremes.
  function automatic logic [COORD_WIDTH-1:0] rand_coord(int mode);
    case (mode)
      0:       return COORD_WIDTH'($urandom_range(16)) - COORD_WIDTH'(8);
      1:       return COORD_WIDTH'($urandom_range(600)) - COORD_WIDTH'(300);
      2:       return COORD_WIDTH'($urandom());
      default: begin
        case ($urandom_range(3))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  initial begin
    int mode, sel, nv;
    bit paused_mid;
    paused_mid = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Vertices before any query are tested against the origin.
    send_item(KIND_VERTEX, 0, 0, 1'b1);
    send_item(KIND_VERTEX, 5, -3, 1'b1);
    // Query with tlast set; the flag is ignored. Square around the point.
    send_item(KIND_QUERY, 0, 0, 1'b1);
    send_item(KIND_VERTEX, -10, -10, 1'b0);
    send_item(KIND_VERTEX, 10, -10, 1'b0);
    send_item(KIND_VERTEX, 10, 10, 1'b0);
    send_item(KIND_VERTEX, -10, 10, 1'b1);
    // Point on an edge of a triangle.
    send_item(KIND_QUERY, 10, 0, 1'b0);
    send_item(KIND_VERTEX, -10, -10, 1'b0);
    send_item(KIND_VERTEX, 10, -10, 1'b0);
    send_item(KIND_VERTEX, 10, 10, 1'b1);
    // The same point kept for a second polygon after the last vertex.
    send_item(KIND_VERTEX, 20, 20, 1'b0);
    send_item(KIND_VERTEX, 30, -20, 1'b1);
    // Extreme triangle: point on a vertex, on the diagonal, and inside.
    send_item(KIND_QUERY, -32768, -32768, 1'b0);
    send_item(KIND_VERTEX, -32768, -32768, 1'b0);
    send_item(KIND_VERTEX, 32767, -32768, 1'b0);
    send_item(KIND_VERTEX, 32767, 32767, 1'b1);
    send_item(KIND_QUERY, 0, 0, 1'b0);
    send_item(KIND_VERTEX, -32768, -32768, 1'b0);
    send_item(KIND_VERTEX, 32767, -32768, 1'b0);
    send_item(KIND_VERTEX, 32767, 32767, 1'b1);
    send_item(KIND_QUERY, 1, -1, 1'b0);
    send_item(KIND_VERTEX, -32768, -32768, 1'b0);
    send_item(KIND_VERTEX, 32767, -32768, 1'b0);
    send_item(KIND_VERTEX, 32767, 32767, 1'b1);
    drain_results();

    // Random polygons, mostly led by a fresh query point, with some noise.
    while (items_sent < 550) begin
      quiet = (items_sent >= 250 && items_sent < 350);
      if (!paused_mid && items_sent >= 450) begin
        drain_results();
        paused_mid = 1'b1;
      end
      sel  = $urandom_range(99);
      mode = (sel < 45) ? 0 : (sel < 75) ? 1 : (sel < 92) ? 2 : 3;
      if ($urandom_range(99) < 85)
        send_item(KIND_QUERY, int'(rand_coord(mode)), int'(rand_coord(mode)),
                  1'($urandom_range(1)));
      nv = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
      for (int i = 0; i < nv; i++) begin
        // Now and then a query breaks into the polygon and restarts it.
        if ($urandom_range(99) < 3)
          send_item(KIND_QUERY, int'(rand_coord(mode)), int'(rand_coord(mode)),
                    1'($urandom_range(1)));
        send_item(KIND_VERTEX, int'(rand_coord(mode)), int'(rand_coord(mode)),
                  i == nv - 1);
      end
    end
    quiet = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d items; checked %0d polygon results.", items_sent,
             n_outside + n_boundary + n_inside);
    $display("Locations seen: %0d outside, %0d on the boundary, %0d inside.",
             n_outside, n_boundary, n_inside);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
sv/pip_pkg.sv
sv/pip_front.sv
sv/pip_edge_prod.sv
sv/point_in_polygon_test.sv
verif/point_in_polygon_test_checker.sv
verif/point_in_polygon_test_tb.sv
